[rtl/pwc_pkg.sv]
// shared constants and types for the pulse width capture block
`timescale 1ns / 1ps

package pwc_pkg;

    localparam int DEF_NUM_CHANNELS = 8;
    localparam int DEF_COUNTER_BITS = 16;

    localparam int CHANNEL_W = 3;
    localparam int VALUE_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd1;

    localparam logic [VALUE_W-1:0] PULSE_MIN_RESET = 16'd1000;
    localparam logic [VALUE_W-1:0] PULSE_MAX_RESET = 16'd2000;

    // us = ticks * 32 / 50 = (ticks * 16) / 25
    // ticks at or above this give at least 65536 us, so they all clamp alike
    localparam int SAT_W = 17;
    localparam logic [SAT_W-1:0] TICKS_SAT = 17'd102400;

    localparam int SCALED_W    = SAT_W + 4;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;
    localparam int PROD_W      = SCALED_W + RECIP_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef struct packed {
        logic                 s1_read;
        logic                 valid;
        logic [CHANNEL_W-1:0] channel;
        logic [SAT_W-1:0]     ticks_sat;
    } rmw_out_t;

endpackage

[rtl/pwc_if.sv]
// handshake channels for capture events and width results
`timescale 1ns / 1ps

interface pwc_in_if
    import pwc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [CHANNEL_W-1:0] channel;
    logic [VALUE_W-1:0]   capture_value;

    modport source (output valid, output action, output channel, output capture_value,
                    input ready);
    modport sink (input valid, input action, input channel, input capture_value,
                  output ready);
endinterface

interface pwc_out_if
    import pwc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] read_channel;
    logic [VALUE_W-1:0]   pulse_us;

    modport source (output valid, output read_channel, output pulse_us, input ready);
    modport sink (input valid, input read_channel, input pulse_us, output ready);
endinterface

[rtl/pwc_chan_rmw.sv]
// per-channel edge state memory with read-modify-write and write forwarding
`timescale 1ns / 1ps

module pwc_chan_rmw
    import pwc_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc,
    input  logic                 action,
    input  logic [CHANNEL_W-1:0] channel,
    input  logic [VALUE_W-1:0]   capture_value,
    output rmw_out_t             rmw_out
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ENTRY_W  = 1 + 2 * COUNTER_BITS;
    localparam logic [4:0] NUM_CH_L = 5'(NUM_CHANNELS);

    logic [ENTRY_W-1:0]      mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [ENTRY_W-1:0]      rdata_reg;
    logic                    valid_rd_reg;

    logic                    in_range;
    logic [CH_IDX_W-1:0]     addr0;
    logic [31:0]             cv_ext;

    logic                    s1_valid_reg;
    logic                    s1_action_reg;
    logic                    s1_in_range_reg;
    logic [CH_IDX_W-1:0]     s1_addr_reg;
    logic [CHANNEL_W-1:0]    s1_channel_reg;
    logic [COUNTER_BITS-1:0] s1_stamp_reg;

    logic                    fwd_valid_reg;
    logic [CH_IDX_W-1:0]     fwd_addr_reg;
    logic [ENTRY_W-1:0]      fwd_entry_reg;

    logic [ENTRY_W-1:0]      cur_entry;
    logic                    cur_expect;
    logic [COUNTER_BITS-1:0] cur_rise;
    logic [COUNTER_BITS-1:0] cur_high;
    logic                    wr_en;
    logic [ENTRY_W-1:0]      wr_entry;
    logic [32:0]             ticks_ext;
    logic [SAT_W-1:0]        ticks_sat_next;

    logic                    res_valid_reg;
    logic [CHANNEL_W-1:0]    res_channel_reg;
    logic [SAT_W-1:0]        res_ticks_reg;

    assign in_range = ({2'b00, channel} < NUM_CH_L);
    assign addr0    = CH_IDX_W'({2'b00, channel});
    assign cv_ext   = {16'b0, capture_value};

    // memory read port and write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wr_entry;
        end
        if (acc && in_range)
        begin
            rdata_reg    <= mem[addr0];
            valid_rd_reg <= valid_reg[addr0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end
            s1_valid_reg  <= acc;
            fwd_valid_reg <= wr_en;
            res_valid_reg <= s1_valid_reg && s1_action_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_action_reg   <= action;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= addr0;
            s1_channel_reg  <= channel;
            s1_stamp_reg    <= cv_ext[COUNTER_BITS-1:0];
        end
        fwd_addr_reg    <= s1_addr_reg;
        fwd_entry_reg   <= wr_entry;
        res_channel_reg <= s1_channel_reg;
        res_ticks_reg   <= ticks_sat_next;
    end

    // entry that the previous cycle wrote is newer than the memory output
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur_entry = fwd_entry_reg;
        end
        else if (valid_rd_reg)
        begin
            cur_entry = rdata_reg;
        end
        else
        begin
            cur_entry = '0;
        end
    end

    assign cur_expect = cur_entry[ENTRY_W-1];
    assign cur_rise   = cur_entry[2*COUNTER_BITS-1:COUNTER_BITS];
    assign cur_high   = cur_entry[COUNTER_BITS-1:0];

    assign wr_en = s1_valid_reg && !s1_action_reg && s1_in_range_reg;

    always_comb
    begin
        if (!cur_expect)
        begin
            wr_entry = {1'b1, s1_stamp_reg, cur_high};
        end
        else
        begin
            wr_entry = {1'b0, cur_rise, s1_stamp_reg - cur_rise};
        end
    end

    assign ticks_ext      = s1_in_range_reg ? 33'(cur_high) : 33'd0;
    assign ticks_sat_next = (ticks_ext >= 33'(TICKS_SAT)) ? TICKS_SAT
                                                          : ticks_ext[SAT_W-1:0];

    assign rmw_out = '{s1_read:   s1_valid_reg && s1_action_reg,
                       valid:     res_valid_reg,
                       channel:   res_channel_reg,
                       ticks_sat: res_ticks_reg};

endmodule

[rtl/pwm_pulse_width_capture.sv]
// top level of the pulse width capture block
`timescale 1ns / 1ps

// Measures pulse high time on up to NUM_CHANNELS capture channels.
// The capture channel takes one item per transfer: action 0 is an edge event
// with the latched counter value, action 1 reads a channel's width. Each
// channel alternates between arming on a rising and a falling edge.
// A read returns one item on the result channel: the channel number and the
// width in microseconds, clamped to [pulse_min_us, pulse_max_us] and offset
// by pulse_min_us. Edge events return nothing.
// Throughput is one item per cycle while capture ready is high; the
// per-channel state is one entry of a single memory, read one cycle and
// written back the next, with the last write forwarded to a following
// item on the same channel. A read passes through memory read, update and
// saturation, reciprocal multiply, and clamp into an 8-entry queue.
// When the receiver stalls, results collect in the queue and the capture
// channel drops ready once queued plus in-flight reads fill it.
// Reset arms every channel for a rising edge with zero width and loads the
// default clamp limits; configuration writes take effect at once.

module pwm_pulse_width_capture
    import pwc_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    pwc_in_if.sink                capture,
    pwc_out_if.source             result
);

    logic [VALUE_W-1:0]    pulse_min_reg;
    logic [VALUE_W-1:0]    pulse_max_reg;

    logic                  acc;
    rmw_out_t              rmw_out;

    logic                  s3_valid_reg;
    logic [CHANNEL_W-1:0]  s3_channel_reg;
    logic [PROD_W-1:0]     s3_prod_reg;
    logic [PROD_W-1:0]     prod_next;

    logic [SAT_W-1:0]      us;
    logic [SAT_W-1:0]      min_ext;
    logic [SAT_W-1:0]      max_ext;
    logic [SAT_W-1:0]      clamped;
    logic [SAT_W-1:0]      offset;
    logic [VALUE_W-1:0]    pulse_next;

    logic [CHANNEL_W+VALUE_W-1:0] fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_CNT_W-1:0] reserved;
    logic                  push;
    logic                  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg <= PULSE_MIN_RESET;
            pulse_max_reg <= PULSE_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PULSE_MIN: pulse_min_reg <= cfg_wdata;
                REG_PULSE_MAX: pulse_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign reserved = count_reg + {3'b000, rmw_out.s1_read} + {3'b000, rmw_out.valid}
                    + {3'b000, s3_valid_reg};

    assign capture.ready = (reserved < FIFO_CNT_W'(FIFO_DEPTH));
    assign acc           = capture.valid && capture.ready;

    pwc_chan_rmw #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_chan_rmw (
        .clk           (clk),
        .rst_n         (rst_n),
        .acc           (acc),
        .action        (capture.action),
        .channel       (capture.channel),
        .capture_value (capture.capture_value),
        .rmw_out       (rmw_out)
    );

    // divide by 25 as multiply by reciprocal
    assign prod_next = PROD_W'({rmw_out.ticks_sat, 4'b0000}) * PROD_W'(RECIP_25);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= rmw_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_channel_reg <= rmw_out.channel;
        s3_prod_reg    <= prod_next;
    end

    assign us      = s3_prod_reg[RECIP_SHIFT+SAT_W-1:RECIP_SHIFT];
    assign min_ext = {1'b0, pulse_min_reg};
    assign max_ext = {1'b0, pulse_max_reg};

    always_comb
    begin
        if (us > max_ext)
        begin
            clamped = max_ext;
        end
        else if (us < min_ext)
        begin
            clamped = min_ext;
        end
        else
        begin
            clamped = us;
        end
    end

    assign offset     = clamped - min_ext;
    assign pulse_next = (clamped < min_ext) ? '0 : offset[VALUE_W-1:0];

    // result queue
    assign push = s3_valid_reg;
    assign pop  = result.valid && result.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= {s3_channel_reg, pulse_next};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign result.valid        = (count_reg != '0);
    assign result.read_channel = fifo_reg[rd_ptr_reg][CHANNEL_W+VALUE_W-1:VALUE_W];
    assign result.pulse_us     = fifo_reg[rd_ptr_reg][VALUE_W-1:0];

endmodule

[rtl/pwc_checker.sv]
// port-level assertions for the pulse width capture block
`timescale 1ns / 1ps

module pwc_checker
    import pwc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  in_action,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [CHANNEL_W-1:0]  out_channel,
    input logic [VALUE_W-1:0]    out_pulse
);

    logic [4:0]         pending_reg;
    logic [VALUE_W-1:0] min_reg;
    logic [VALUE_W-1:0] max_reg;
    logic               rd_xfer;
    logic               out_xfer;

    assign rd_xfer  = in_valid && in_ready && in_action;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            min_reg     <= PULSE_MIN_RESET;
            max_reg     <= PULSE_MAX_RESET;
        end
        else
        begin
            pending_reg <= pending_reg + {4'b0000, rd_xfer} - {4'b0000, out_xfer};
            if (cfg_we && (cfg_index == REG_PULSE_MIN))
            begin
                min_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_PULSE_MAX))
            begin
                max_reg <= cfg_wdata;
            end
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_pulse))
        else $error("result changed while stalled");

    // every result answers an earlier read
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 5'd0)
        else $error("result without a pending read");

    // width never exceeds the clamp window
    a_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (min_reg <= max_reg) |-> out_pulse <= (max_reg - min_reg))
        else $error("pulse width outside clamp window");

endmodule

bind pwm_pulse_width_capture pwc_checker u_pwc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (capture.valid),
    .in_ready    (capture.ready),
    .in_action   (capture.action),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_channel (result.read_channel),
    .out_pulse   (result.pulse_us)
);
